### design/scmd_pkg.sv
`default_nettype none
package scmd_pkg;

    localparam int unsigned CMD_W   = 8;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned ACT_W   = 2;
    localparam int unsigned STAT_W  = 2;

    localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_BASE    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SLEEP   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_RECHECK = 3'd3;
    localparam logic [PHASE_W-1:0] PH_WRITE   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_CHANGE  = 3'd5;

    localparam logic [MODE_W-1:0] MODE_START = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

    localparam logic [ACT_W-1:0] ACT_READ  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DONE  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BUS    = 2'd1;
    localparam logic [STAT_W-1:0] ST_DEVICE = 2'd2;
    localparam logic [STAT_W-1:0] ST_TIMING = 2'd3;

    localparam logic [CMD_W-1:0] CHIPSTAT_BITS = 8'hE0;
    localparam logic [CMD_W-1:0] COUNTER_BITS  = 8'h0F;
    localparam logic [CMD_W-1:0] ERROR_BIT     = 8'h10;
    localparam logic [CMD_W-1:0] SLEEP_STATE   = 8'h20;
    localparam logic [CNT_W-1:0] TRIES_RESET   = 4'd5;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [CMD_W-1:0]   held_command;
        logic [CNT_W-1:0]   running_count;
        logic [CNT_W-1:0]   agreed_count;
        logic [CNT_W-1:0]   sleep_tries;
        logic [CNT_W-1:0]   loop_tries;
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [ACT_W-1:0]  action;
        logic [CMD_W-1:0]  write_data;
        logic [STAT_W-1:0] status;
    } t_result;

endpackage
`default_nettype wire

### design/scmd_core.sv
`default_nettype none
module scmd_core (
    input  scmd_pkg::t_state               i_state,
    input  logic [scmd_pkg::CNT_W-1:0]     i_max_tries,
    input  logic [scmd_pkg::MODE_W-1:0]    i_mode,
    input  logic [scmd_pkg::CMD_W-1:0]     i_command_code,
    input  logic [scmd_pkg::CMD_W-1:0]     i_response_byte,
    input  logic                           i_bus_error,
    output scmd_pkg::t_state               o_state,
    output scmd_pkg::t_result              o_result
);
    import scmd_pkg::*;

    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] sleep_inc;
    logic [CNT_W-1:0] loop_inc;
    logic             sleep_out;
    logic             loop_out;

    assign cnt       = i_response_byte[CNT_W-1:0];
    assign sleep_inc = i_state.sleep_tries + 4'd1;
    assign loop_inc  = i_state.loop_tries + 4'd1;
    assign sleep_out = sleep_inc >= i_max_tries;
    assign loop_out  = loop_inc >= i_max_tries;

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        case (i_mode)
            MODE_START: begin
                o_state.held_command = i_command_code;
                o_state.sleep_tries  = '0;
                o_state.loop_tries   = '0;
                o_state.phase        = PH_BASE;
                o_result.valid       = 1'b1;
                o_result.action      = ACT_READ;
            end
            MODE_WRITE: begin
                if (i_state.phase == PH_WRITE) begin
                    o_result.valid = 1'b1;
                    if (i_bus_error) begin
                        o_state.phase   = PH_IDLE;
                        o_result.action = ACT_DONE;
                        o_result.status = ST_BUS;
                    end else begin
                        o_state.loop_tries = '0;
                        o_state.phase      = PH_CHANGE;
                        o_result.action    = ACT_READ;
                    end
                end
            end
            MODE_READ: begin
                if (i_state.phase inside {PH_BASE, PH_SLEEP, PH_RECHECK, PH_CHANGE}) begin
                    o_result.valid  = 1'b1;
                    o_result.action = ACT_READ;
                    if (i_bus_error) begin
                        o_state.phase   = PH_IDLE;
                        o_result.action = ACT_DONE;
                        o_result.status = ST_BUS;
                    end else if ((i_response_byte & ERROR_BIT) != '0) begin
                        o_state.phase   = PH_IDLE;
                        o_result.action = ACT_DONE;
                        o_result.status = ST_DEVICE;
                    end else begin
                        case (i_state.phase)
                            PH_BASE: begin
                                o_state.running_count = cnt;
                                o_state.sleep_tries   = '0;
                                o_state.loop_tries    = '0;
                                o_state.phase         = PH_SLEEP;
                            end
                            PH_SLEEP: begin
                                if ((i_response_byte & CHIPSTAT_BITS) == SLEEP_STATE) begin
                                    o_state.phase = PH_RECHECK;
                                end else begin
                                    o_state.sleep_tries = sleep_inc;
                                    if (sleep_out) begin
                                        o_state.phase   = PH_IDLE;
                                        o_result.action = ACT_DONE;
                                        o_result.status = ST_TIMING;
                                    end
                                end
                            end
                            PH_RECHECK: begin
                                if (cnt == i_state.running_count) begin
                                    o_state.agreed_count = cnt;
                                    o_state.phase        = PH_WRITE;
                                    o_result.action      = ACT_WRITE;
                                    o_result.write_data  = i_state.held_command;
                                end else begin
                                    o_state.running_count = cnt;
                                    o_state.loop_tries    = loop_inc;
                                    if (loop_out) begin
                                        o_state.phase   = PH_IDLE;
                                        o_result.action = ACT_DONE;
                                        o_result.status = ST_TIMING;
                                    end else begin
                                        o_state.sleep_tries = '0;
                                        o_state.phase       = PH_SLEEP;
                                    end
                                end
                            end
                            default: begin
                                if (cnt != i_state.agreed_count) begin
                                    o_state.phase   = PH_IDLE;
                                    o_result.action = ACT_DONE;
                                    o_result.status = ST_OK;
                                end else begin
                                    o_state.loop_tries = loop_inc;
                                    if (loop_out) begin
                                        o_state.phase   = PH_IDLE;
                                        o_result.action = ACT_DONE;
                                        o_result.status = ST_TIMING;
                                    end
                                end
                            end
                        endcase
                    end
                end
            end
            default: begin
                o_result.valid = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

### design/sensor_command_handshake.sv
// sensor command sequencer, host side
// input stream: one word per completed bus access (or a start request)
//   tuser = mode (start, read done, write done), tdata = command, response, bus error
// output stream: one word per accepted input word that is expected in the
//   current phase, telling the host what to do next (read, write, finished+status)
// words whose mode does not fit the current phase are taken and dropped
// config channel: retry limit, 4 bits, write only while no sequence is in flight
// the result is registered: it appears on the output in the cycle after the input word is
//   taken; one input word per cycle is sustained while i_m_tready is high, limited by the
//   single output register
// the output register holds its word while i_m_tready is low; a new input word
//   is taken in that cycle only if the output register is empty or being drained
// reset (i_rst_n low, synchronous): sequencer idle, retry limit back to 5,
//   output empty
`default_nettype none
module sensor_command_handshake (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [7:0] command_code, [15:8] response_byte, [16] bus_error, [23:17] zero
    input  logic [23:0] i_s_tdata,
    // [1:0] mode
    input  logic [scmd_pkg::MODE_W-1:0] i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] write_data, [9:8] status, [15:10] zero
    output logic [15:0] o_m_tdata,
    // [1:0] action
    output logic [scmd_pkg::ACT_W-1:0] o_m_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [scmd_pkg::CNT_W-1:0] i_cfg_data
);
    import scmd_pkg::*;

    t_state           r_state;
    t_state           n_state;
    t_result          step_res;
    logic [CNT_W-1:0] r_max_tries;
    logic             r_out_valid;
    logic [ACT_W-1:0] r_out_action;
    logic [CMD_W-1:0] r_out_wdata;
    logic [STAT_W-1:0] r_out_status;
    logic             s_accept;

    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    scmd_core u_core (
        .i_state         (r_state),
        .i_max_tries     (r_max_tries),
        .i_mode          (i_s_tuser),
        .i_command_code  (i_s_tdata[7:0]),
        .i_response_byte (i_s_tdata[15:8]),
        .i_bus_error     (i_s_tdata[16]),
        .o_state         (n_state),
        .o_result        (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_max_tries <= TRIES_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max_tries <= i_cfg_data;
            end
            if (s_accept) begin
                r_state     <= n_state;
                r_out_valid <= step_res.valid;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out_action <= step_res.action;
            r_out_wdata  <= step_res.write_data;
            r_out_status <= step_res.status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_action;
    assign o_m_tdata  = {6'd0, r_out_status, r_out_wdata};

endmodule
`default_nettype wire

### design/scmd_checker.sv
`default_nettype none
module scmd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        o_s_tready,
    input  logic [scmd_pkg::MODE_W-1:0] i_s_tuser,
    input  logic        o_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] o_m_tdata,
    input  logic [scmd_pkg::ACT_W-1:0] o_m_tuser
);
    import scmd_pkg::*;

    // stalled word stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("output word changed while stalled");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // a start word always answers with a plain read request
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == MODE_START
        |=> o_m_tvalid && o_m_tuser == ACT_READ && o_m_tdata == 16'd0)
        else $error("start word not answered by read request");

    // status only carried on finished words
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != ACT_DONE |-> o_m_tdata[9:8] == ST_OK)
        else $error("status set on non-final word");

    // input stalled only behind a stalled output
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("input stalled without output backpressure");

endmodule

bind sensor_command_handshake scmd_checker u_scmd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .i_s_tuser   (i_s_tuser),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tuser   (o_m_tuser)
);
`default_nettype wire

### dv/sensor_command_handshake_tb.sv
`timescale 1ns / 100ps
module sensor_command_handshake_tb;
    import scmd_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SHOW_LIMIT = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [MODE_W-1:0] MODE_BOGUS = 2'd3;
    localparam int LOOP_SLEEP = 0;
    localparam int LOOP_RECHECK = 1;
    localparam int LOOP_CHANGE = 2;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [CMD_W-1:0]  write_data;
        logic [STAT_W-1:0] status;
    } t_reply;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [23:0] i_s_tdata = '0;
    logic [MODE_W-1:0] i_s_tuser = '0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;
    logic [ACT_W-1:0] o_m_tuser;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_data = '0;

    // sequencer state as predicted
    logic [PHASE_W-1:0] seq_phase = PH_IDLE;
    logic [CMD_W-1:0] held_cmd = '0;
    logic [CNT_W-1:0] run_cnt = '0;
    logic [CNT_W-1:0] agreed_cnt = '0;
    logic [CNT_W-1:0] sleep_tries = '0;
    logic [CNT_W-1:0] loop_tries = '0;
    logic [CNT_W-1:0] tries_limit = TRIES_RESET;

    t_reply pending_replies[$];
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int words_sent = 0;
    int words_answered = 0;
    int results_checked = 0;
    int limits_written = 0;
    int mismatches = 0;
    int cycles = 0;

    sensor_command_handshake uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata),
        .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata),
        .o_m_tuser(o_m_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     pending_replies.size());
            $display("sensor_command_handshake verification failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    function automatic bit wrap_up(output t_reply r, input logic [STAT_W-1:0] st);
        seq_phase = PH_IDLE;
        r = {ACT_DONE, 8'h00, st};
        return 1'b1;
    endfunction

    // one more failed try; true once the limit is reached (zero acts as one)
    function automatic bit tries_spent(inout logic [CNT_W-1:0] tries);
        tries = tries + 1'b1;
        return tries >= tries_limit;
    endfunction

    function automatic bit next_reply(input logic [MODE_W-1:0] mode,
                                      input logic [CMD_W-1:0] cmd,
                                      input logic [CMD_W-1:0] rsp,
                                      input logic berr, output t_reply r);
        logic [CNT_W-1:0] cnt;
        cnt = rsp[CNT_W-1:0];
        r = {ACT_READ, 8'h00, ST_OK};
        if (mode == MODE_START) begin
            held_cmd = cmd;
            sleep_tries = '0;
            loop_tries = '0;
            seq_phase = PH_BASE;
            return 1'b1;
        end
        if (mode == MODE_WRITE) begin
            if (seq_phase != PH_WRITE)
                return 1'b0;
            if (berr)
                return wrap_up(r, ST_BUS);
            loop_tries = '0;
            seq_phase = PH_CHANGE;
            return 1'b1;
        end
        if (mode != MODE_READ)
            return 1'b0;
        if (seq_phase != PH_BASE && seq_phase != PH_SLEEP && seq_phase != PH_RECHECK &&
            seq_phase != PH_CHANGE)
            return 1'b0;
        if (berr)
            return wrap_up(r, ST_BUS);
        if ((rsp & ERROR_BIT) != 0)
            return wrap_up(r, ST_DEVICE);
        case (seq_phase)
            PH_BASE: begin
                run_cnt = cnt;
                sleep_tries = '0;
                loop_tries = '0;
                seq_phase = PH_SLEEP;
            end
            PH_SLEEP: begin
                if ((rsp & CHIPSTAT_BITS) == SLEEP_STATE)
                    seq_phase = PH_RECHECK;
                else if (tries_spent(sleep_tries))
                    return wrap_up(r, ST_TIMING);
            end
            PH_RECHECK: begin
                if (cnt == run_cnt) begin
                    agreed_cnt = cnt;
                    seq_phase = PH_WRITE;
                    r = {ACT_WRITE, held_cmd, ST_OK};
                end else begin
                    run_cnt = cnt;
                    if (tries_spent(loop_tries))
                        return wrap_up(r, ST_TIMING);
                    sleep_tries = '0;
                    seq_phase = PH_SLEEP;
                end
            end
            default: begin
                if (cnt != agreed_cnt)
                    return wrap_up(r, ST_OK);
                if (tries_spent(loop_tries))
                    return wrap_up(r, ST_TIMING);
            end
        endcase
        return 1'b1;
    endfunction

    task automatic send_word(input logic [MODE_W-1:0] mode, input logic [CMD_W-1:0] cmd,
                             input logic [CMD_W-1:0] rsp, input logic berr);
        t_reply r;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata = {7'd0, berr, rsp, cmd};
        i_s_tuser = mode;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        words_sent++;
        if (next_reply(mode, cmd, rsp, berr, r)) begin
            pending_replies.push_back(r);
            words_answered++;
        end
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_checked++;
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("unexpected word: action %0d data %02h status %0d",
                             o_m_tuser, o_m_tdata[7:0], o_m_tdata[9:8]);
            end else begin
                want = pending_replies.pop_front();
                if (o_m_tuser !== want.action || o_m_tdata[7:0] !== want.write_data ||
                    o_m_tdata[9:8] !== want.status) begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display({"mismatch: expected action %0d data %02h status %0d,",
                                  " got %0d %02h %0d"},
                                 want.action, want.write_data, want.status,
                                 o_m_tuser, o_m_tdata[7:0], o_m_tdata[9:8]);
                end
            end
        end
    end

    // drop valid, wait for every predicted word, then let ignored words clear
    task automatic settle();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pending_replies.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [CNT_W-1:0] value);
        settle();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        tries_limit = value;
        limits_written++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic test_directed_paths();
        send_word(MODE_READ, 8'h00, 8'h0F, 1'b0);   // idle, ignored
        send_word(MODE_BOGUS, 8'hFF, 8'hFF, 1'b1);
        send_word(MODE_WRITE, 8'h00, 8'h00, 1'b0);
        send_word(MODE_START, 8'hFF, 8'h00, 1'b0);
        send_word(MODE_READ, 8'h00, 8'h0F, 1'b0);
        send_word(MODE_READ, 8'h00, 8'h2F, 1'b0);
        send_word(MODE_READ, 8'h00, 8'h0F, 1'b0);
        send_word(MODE_READ, 8'h00, 8'h0F, 1'b0);   // waiting for write, ignored
        send_word(MODE_WRITE, 8'h00, 8'h00, 1'b0);
        send_word(MODE_READ, 8'h00, 8'h0F, 1'b0);
        send_word(MODE_READ, 8'h00, 8'hE0, 1'b0);
        send_word(MODE_START, 8'h00, 8'hFF, 1'b1);
        send_word(MODE_READ, 8'hFF, 8'hFF, 1'b1);
        send_word(MODE_START, 8'hA5, 8'h00, 1'b0);
        send_word(MODE_READ, 8'h00, 8'h10, 1'b0);
        send_word(MODE_START, 8'h5A, 8'h00, 1'b0);
        send_word(MODE_READ, 8'h00, 8'h03, 1'b0);
        send_word(MODE_READ, 8'h00, 8'hC3, 1'b0);
        send_word(MODE_READ, 8'h00, 8'h20, 1'b0);
        send_word(MODE_READ, 8'h00, 8'h24, 1'b0);
        send_word(MODE_START, 8'h3C, 8'h00, 1'b0);  // restart while busy
        send_word(MODE_READ, 8'h00, 8'h01, 1'b0);
        send_word(MODE_READ, 8'h00, 8'h21, 1'b0);
        send_word(MODE_READ, 8'h00, 8'h01, 1'b0);
        send_word(MODE_WRITE, 8'h00, 8'h00, 1'b1);
    endtask

    // steer one sequence until the chosen polling loop runs out of tries
    task automatic chase_timeout(input int loop_kind);
        logic [CMD_W-1:0] rsp;
        send_word(MODE_START, 8'(loop_kind + 8'h40), 8'h00, 1'b0);
        while (seq_phase != PH_IDLE) begin
            rsp = 8'h07;
            case (seq_phase)
                PH_SLEEP: rsp = (loop_kind == LOOP_SLEEP) ? 8'hE7 : {4'h2, run_cnt};
                PH_RECHECK: rsp = {4'h0, run_cnt + CNT_W'(loop_kind == LOOP_RECHECK)};
                PH_CHANGE: rsp = {4'h0, agreed_cnt};
                default: rsp = 8'h07;
            endcase
            if (seq_phase == PH_WRITE)
                send_word(MODE_WRITE, 8'h00, 8'h00, 1'b0);
            else
                send_word(MODE_READ, 8'h00, rsp, 1'b0);
        end
    endtask

    task automatic test_retry_limits();
        logic [CNT_W-1:0] limits[4];
        limits = '{4'd0, 4'd1, 4'd15, TRIES_RESET};
        foreach (limits[i]) begin
            write_limit(limits[i]);
            chase_timeout(LOOP_SLEEP);
            chase_timeout(LOOP_RECHECK);
            chase_timeout(LOOP_CHANGE);
        end
    endtask

    function automatic logic [CMD_W-1:0] steered_response();
        logic [CMD_W-1:0] rsp;
        rsp = CMD_W'($urandom_range(0, 255)) & ~ERROR_BIT;
        if ($urandom_range(0, 99) < 3)
            rsp = rsp | ERROR_BIT;
        case (seq_phase)
            PH_SLEEP:
                if ($urandom_range(0, 99) < 60)
                    rsp = (rsp & ~CHIPSTAT_BITS) | SLEEP_STATE;
            PH_RECHECK:
                if ($urandom_range(0, 99) < 60)
                    rsp[CNT_W-1:0] = run_cnt;
            PH_CHANGE:
                if ($urandom_range(0, 99) < 50)
                    rsp[CNT_W-1:0] = agreed_cnt;
            default: ;
        endcase
        return rsp;
    endfunction

    task automatic run_sequence();
        send_word(MODE_START, CMD_W'($urandom_range(0, 255)), CMD_W'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
        while (seq_phase != PH_IDLE) begin
            if ($urandom_range(0, 99) < 6)
                send_word(MODE_W'($urandom_range(0, 3)), CMD_W'($urandom_range(0, 255)),
                          CMD_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else if (seq_phase == PH_WRITE)
                send_word(MODE_WRITE, CMD_W'($urandom_range(0, 255)),
                          CMD_W'($urandom_range(0, 255)), $urandom_range(0, 99) < 4);
            else
                send_word(MODE_READ, CMD_W'($urandom_range(0, 255)), steered_response(),
                          $urandom_range(0, 99) < 3);
        end
    endtask

    task automatic test_random_traffic();
        int idle_mix[4][2];
        int goal;
        idle_mix = '{'{0, 0}, '{76, 0}, '{0, 76}, '{19, 19}};
        for (int p = 0; p < 4; p++) begin
            write_limit(CNT_W'($urandom_range(2, 15)));
            src_idle_pct = idle_mix[p][0];
            sink_stall_pct = idle_mix[p][1];
            goal = words_answered + 315;
            while (words_answered < goal)
                run_sequence();
        end
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed_paths();
        test_retry_limits();
        test_random_traffic();
        settle();
        $display("sent %0d words, %0d answered, %0d results checked", words_sent,
                 words_answered, results_checked);
        $display("retry limit written %0d times incl. 0, 1 and 15, four flow-control mixes",
                 limits_written);
        if (mismatches == 0) begin
            $display("sensor_command_handshake verification clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("sensor_command_handshake verification failed");
        end
        $finish;
    end

endmodule

### sim.f
design/scmd_pkg.sv
design/scmd_core.sv
design/sensor_command_handshake.sv
design/scmd_checker.sv
dv/sensor_command_handshake_tb.sv
